// ----- src/dda_ray_setup_assert.svh -----
// Assertion macros for the ray setup block.
// Each checks on the rising edge of clk; DDA_ASSERT is off while rst is high.
`ifndef DDA_RAY_SETUP_ASSERT_SVH
`define DDA_RAY_SETUP_ASSERT_SVH
`ifndef SYNTHESIS
`define DDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dda_ray_setup: assertion failed");
`define DDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dda_ray_setup: assertion failed");
`else
`define DDA_ASSERT(lbl, prop)
`define DDA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- src/dda_pkg.sv -----
package dda_pkg;

  localparam int unsigned SCREEN_COLUMNS_DEF = 1024;

  localparam int unsigned COL_W  = 10;
  localparam int unsigned DIR_W  = 18;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned RAY_W  = 19;
  localparam int unsigned CAM_W  = 28;
  localparam int unsigned MAG_W  = 19;
  localparam int unsigned QUO_W  = 33;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned CFG_W  = 24;

  localparam logic [RAY_W-1:0]  RAY_MIN_C = 19'h40000;
  localparam logic [RAY_W-1:0]  RAY_MAX_C = 19'h3FFFF;
  localparam logic [DIST_W-1:0] DIST_MAX  = 32'hFFFF_FFFF;
  localparam logic [1:0]        STEP_POS  = 2'b01;
  localparam logic [1:0]        STEP_NEG  = 2'b11;

  typedef enum logic [2:0] {
    CFG_VIEW_DIR_X   = 3'd0,
    CFG_VIEW_DIR_Y   = 3'd1,
    CFG_CAM_PLANE_X  = 3'd2,
    CFG_CAM_PLANE_Y  = 3'd3,
    CFG_VIEWER_POS_X = 3'd4,
    CFG_VIEWER_POS_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] side_dist_y;
    logic [DIST_W-1:0] side_dist_x;
    logic [DIST_W-1:0] delta_dist_y;
    logic [DIST_W-1:0] delta_dist_x;
    logic [1:0]        step_y_dir;
    logic [1:0]        step_x_dir;
    logic [7:0]        cell_y;
    logic [7:0]        cell_x;
    logic [RAY_W-1:0]  ray_dir_y;
    logic [RAY_W-1:0]  ray_dir_x;
  } ray_t;

  // carried alongside the reciprocal pipeline
  typedef struct packed {
    logic [RAY_W-1:0]  ray_dir;
    logic              zero;
    logic [FRAC_W-1:0] frac;
  } axis_tag_t;

endpackage

// ----- src/dda_cam.sv -----
// camera coordinate: floor(column * 2^17 / SCREEN_COLUMNS) - 2^16
module dda_cam #(
  parameter int unsigned SCREEN_COLUMNS = dda_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vld_in,
  input  logic [dda_pkg::COL_W-1:0]        column,
  output logic                             vld_out,
  output logic signed [dda_pkg::CAM_W-1:0] cam
);
  import dda_pkg::*;

  // column * 2^17 / N = column * A + column * B / N
  localparam longint unsigned ColA   = (64'd1 << 17) / SCREEN_COLUMNS;
  localparam longint unsigned ColB   = (64'd1 << 17) % SCREEN_COLUMNS;
  localparam longint unsigned RecipM = (64'd1 << 32) / SCREEN_COLUMNS;
  localparam logic [16:0] A_C  = 17'(ColA);
  localparam logic [11:0] B_C  = 12'(ColB);
  localparam logic [31:0] M_C  = 32'(RecipM);
  localparam logic [12:0] SC_C = 13'(SCREEN_COLUMNS);

  logic [2:0]  vld;
  logic [26:0] a1, a2;
  logic [21:0] n1, n2;
  logic [9:0]  q0;
  logic [53:0] t;
  logic [22:0] qs, r;
  logic [10:0] qq;
  logic [26:0] camq;

  always_comb begin
    t    = 54'(n1) * 54'(M_C);
    qs   = 23'(q0) * 23'(SC_C);
    r    = 23'(n2) - qs;
    qq   = 11'(q0) + ((r >= 23'(SC_C)) ? 11'd1 : 11'd0);
    camq = a2 + 27'(qq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= 27'(27'(column) * 27'(A_C));
      n1  <= 22'(22'(column) * 22'(B_C));
      q0  <= t[41:32];
      n2  <= n1;
      a2  <= a1;
      cam <= $signed(28'({1'b0, camq}) - 28'd65536);
    end
  end

  assign vld_out = vld[2];

endmodule

// ----- src/dda_recip.sv -----
// pipelined restoring divider: quo = 2^32 / mag, one quotient bit per stage
module dda_recip #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic [dda_pkg::MAG_W-1:0]   mag,
  input  logic [TAG_W-1:0]            tag_in,
  output logic                        vld_out,
  output logic [dda_pkg::QUO_W-1:0]   quo,
  output logic [TAG_W-1:0]            tag_out
);
  import dda_pkg::*;

  logic             vld [0:QUO_W];
  logic [MAG_W-1:0] rem [0:QUO_W];
  logic [QUO_W-1:0] qt  [0:QUO_W];
  logic [MAG_W-1:0] mg  [0:QUO_W];
  logic [TAG_W-1:0] tg  [0:QUO_W];

  assign vld[0] = vld_in;
  assign rem[0] = '0;
  assign qt[0]  = '0;
  assign mg[0]  = mag;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;

    // dividend is a one followed by zeros
    assign trial = {rem[k], (k == 0) ? 1'b1 : 1'b0};
    assign diff  = trial - {1'b0, mg[k]};
    assign ge    = trial >= {1'b0, mg[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        qt[k+1]  <= {qt[k][QUO_W-2:0], ge};
        mg[k+1]  <= mg[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign vld_out = vld[QUO_W];
  assign quo     = qt[QUO_W];
  assign tag_out = tg[QUO_W];

endmodule

// ----- src/dda_side.sv -----
// delta and side distance of one axis, with saturation; two stages
module dda_side #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [dda_pkg::QUO_W-1:0]    quo,
  input  logic [dda_pkg::FRAC_W-1:0]   frac,
  input  logic                         zero,
  input  logic [TAG_W-1:0]             tag_in,
  output logic                         vld_out,
  output logic [dda_pkg::DIST_W-1:0]   delta,
  output logic [dda_pkg::DIST_W-1:0]   side,
  output logic                         clip,
  output logic [TAG_W-1:0]             tag_out
);
  import dda_pkg::*;

  logic [1:0]        vld;
  logic [33:0]       ph;
  logic [32:0]       pl;
  logic              zero1, big1;
  logic [DIST_W-1:0] q1;
  logic [TAG_W-1:0]  tag1;
  logic [34:0]       s;
  logic              s_big;

  // f * q split in halves of q to keep the multipliers at 17x17
  assign s     = 35'(ph) + 35'(pl[32:16]);
  assign s_big = s[34:32] != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph      <= 34'(frac) * 34'(quo[32:16]);
      pl      <= 33'(frac) * 33'(quo[15:0]);
      zero1   <= zero;
      big1    <= quo[32];
      q1      <= quo[31:0];
      tag1    <= tag_in;
      delta   <= (zero1 || big1) ? DIST_MAX : q1;
      side    <= (zero1 || s_big) ? DIST_MAX : s[31:0];
      clip    <= zero1 || big1 || s_big;
      tag_out <= tag1;
    end
  end

  assign vld_out = vld[1];

endmodule

// ----- src/dda_ray_setup.sv -----
// Ray setup for a DDA grid walk, one ray per screen column.
// Input channel s_axis: one item per column, tdata[9:0] = column index.
// Output channel m_axis: one result item per input item, in order.
// Config port: cfg_we/cfg_addr/cfg_data writes view direction, camera
// plane and viewer position (index order as in dda_pkg::cfg_idx_t).
// Write config only while no item is in flight; stages read it live.
// Pipeline: the edge that accepts an input item loads the first of 42
// register stages (3 camera coordinate, 3 ray direction and fraction, 33
// reciprocal divider at one quotient bit a stage, 2 side distance multiply,
// 1 output register); the 33-stage divider sets the depth.
// Throughput: one item per cycle while the pipeline is not stalled.
// Stall: the whole pipeline moves on one enable. When m_axis_tready is low
// the output register holds and one more result drops into a skid
// register; only then does s_axis_tready fall and the pipeline freeze.
// Reset (rst, synchronous) clears all valid bits, the skid register and
// restores the config registers to their default camera.
module dda_ray_setup #(
  parameter int unsigned SCREEN_COLUMNS = dda_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // column[9:0], zero pad
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // ray_dir_x[18:0] ray_dir_y[37:19] cell_x[45:38] cell_y[53:46]
  // step_x_dir[55:54] step_y_dir[57:56] delta_dist_x[89:58]
  // delta_dist_y[121:90] side_dist_x[153:122] side_dist_y[185:154], pad
  output logic [191:0]               m_axis_tdata,
  output logic                       m_axis_tuser,   // saturated[0]
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [dda_pkg::CFG_W-1:0]  cfg_data
);
  import dda_pkg::*;
  `include "dda_ray_setup_assert.svh"

  localparam int unsigned TAG_W = $bits(axis_tag_t);

  // configuration
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [POS_W-1:0]        pos_x, pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x   <= 18'sd65536;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= 18'sd43254;
      pos_x   <= '0;
      pos_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_VIEW_DIR_X:   dir_x   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_VIEW_DIR_Y:   dir_y   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_CAM_PLANE_X:  plane_x <= $signed(cfg_data[DIR_W-1:0]);
        CFG_CAM_PLANE_Y:  plane_y <= $signed(cfg_data[DIR_W-1:0]);
        CFG_VIEWER_POS_X: pos_x   <= cfg_data;
        CFG_VIEWER_POS_Y: pos_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global pipeline enable: frozen only while the skid register is full
  logic skid_valid;
  logic en;
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // camera coordinate, stages 1-3
  logic                    cam_vld;
  logic signed [CAM_W-1:0] cam;

  dda_cam #(.SCREEN_COLUMNS(SCREEN_COLUMNS)) u_cam (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s_axis_tvalid && en),
    .column  (s_axis_tdata[COL_W-1:0]),
    .vld_out (cam_vld),
    .cam     (cam)
  );

  // stage 4: plane * cam
  logic              v4;
  logic signed [45:0] px, py;

  // stage 5: dir + floor(plane*cam / 2^16), clamped to Q3.16
  logic              v5;
  logic [RAY_W-1:0]  rdx5, rdy5;
  logic signed [30:0] sum_x, sum_y;
  logic [RAY_W-1:0]  rdx_c, rdy_c;

  always_comb begin
    sum_x = 31'(dir_x) + 31'($signed(px[45:16]));
    sum_y = 31'(dir_y) + 31'($signed(py[45:16]));
    if (sum_x < -31'sd262144) rdx_c = RAY_MIN_C;
    else if (sum_x > 31'sd262143) rdx_c = RAY_MAX_C;
    else rdx_c = sum_x[RAY_W-1:0];
    if (sum_y < -31'sd262144) rdy_c = RAY_MIN_C;
    else if (sum_y > 31'sd262143) rdy_c = RAY_MAX_C;
    else rdy_c = sum_y[RAY_W-1:0];
  end

  // stage 6: magnitude, zero test and grid-line fraction
  logic              v6;
  logic [MAG_W-1:0]  mag_x, mag_y;
  axis_tag_t         tag_x6, tag_y6;
  logic [MAG_W-1:0]  negx_v, negy_v;

  assign negx_v = MAG_W'(-rdx5);
  assign negy_v = MAG_W'(-rdy5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= cam_vld;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= 46'(plane_x) * 46'(cam);
      py   <= 46'(plane_y) * 46'(cam);
      rdx5 <= rdx_c;
      rdy5 <= rdy_c;
      mag_x <= rdx5[RAY_W-1] ? negx_v : rdx5;
      mag_y <= rdy5[RAY_W-1] ? negy_v : rdy5;
      tag_x6.ray_dir <= rdx5;
      tag_y6.ray_dir <= rdy5;
      tag_x6.zero    <= rdx5 == '0;
      tag_y6.zero    <= rdy5 == '0;
      tag_x6.frac    <= rdx5[RAY_W-1] ? {1'b0, pos_x[15:0]}
                                      : 17'h10000 - {1'b0, pos_x[15:0]};
      tag_y6.frac    <= rdy5[RAY_W-1] ? {1'b0, pos_y[15:0]}
                                      : 17'h10000 - {1'b0, pos_y[15:0]};
    end
  end

  // reciprocal, 33 stages per axis
  logic             dvx, dvy;
  logic [QUO_W-1:0] qx, qy;
  axis_tag_t        tqx, tqy;

  dda_recip #(.TAG_W(TAG_W)) u_recip_x (
    .clk(clk), .rst(rst), .en(en), .vld_in(v6), .mag(mag_x),
    .tag_in(tag_x6), .vld_out(dvx), .quo(qx), .tag_out(tqx)
  );

  dda_recip #(.TAG_W(TAG_W)) u_recip_y (
    .clk(clk), .rst(rst), .en(en), .vld_in(v6), .mag(mag_y),
    .tag_in(tag_y6), .vld_out(dvy), .quo(qy), .tag_out(tqy)
  );

  // side distance, 2 stages per axis
  logic              svx, svy;
  logic [DIST_W-1:0] dlx, dly, sdx, sdy;
  logic              clx, cly;
  logic [RAY_W-1:0]  frx, fry;

  dda_side #(.TAG_W(RAY_W)) u_side_x (
    .clk(clk), .rst(rst), .en(en), .vld_in(dvx), .quo(qx),
    .frac(tqx.frac), .zero(tqx.zero), .tag_in(tqx.ray_dir),
    .vld_out(svx), .delta(dlx), .side(sdx), .clip(clx), .tag_out(frx)
  );

  dda_side #(.TAG_W(RAY_W)) u_side_y (
    .clk(clk), .rst(rst), .en(en), .vld_in(dvy), .quo(qy),
    .frac(tqy.frac), .zero(tqy.zero), .tag_in(tqy.ray_dir),
    .vld_out(svy), .delta(dly), .side(sdy), .clip(cly), .tag_out(fry)
  );

  ray_t res;
  logic res_sat;

  always_comb begin
    res.ray_dir_x    = frx;
    res.ray_dir_y    = fry;
    res.cell_x       = pos_x[23:16];
    res.cell_y       = pos_y[23:16];
    res.step_x_dir   = frx[RAY_W-1] ? STEP_NEG : STEP_POS;
    res.step_y_dir   = fry[RAY_W-1] ? STEP_NEG : STEP_POS;
    res.delta_dist_x = dlx;
    res.delta_dist_y = dly;
    res.side_dist_x  = sdx;
    res.side_dist_y  = sdy;
    res_sat          = clx || cly;
  end

  // output register plus skid register
  logic push;
  logic out_valid;
  ray_t out_data, skid_data;
  logic out_sat, skid_sat;

  assign push = svx && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : res;
      out_sat  <= skid_valid ? skid_sat : res_sat;
    end else if (push) begin
      skid_data <= res;
      skid_sat  <= res_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_data};
  assign m_axis_tuser  = out_sat;

  `DDA_ASSERT(a_skid_needs_out, skid_valid |-> out_valid)
  `DDA_ASSERT(a_skid_fill, $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
  `DDA_ASSERT(a_axes_aligned, (svx == svy) && (dvx == dvy))
  `DDA_ASSERT(a_max_delta_sat,
    (out_valid && (out_data.delta_dist_x == DIST_MAX)) |-> out_sat)
  `DDA_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !skid_valid))

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import dda_pkg::*;

  localparam int unsigned NCOL = SCREEN_COLUMNS_DEF;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dda_ray_setup dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // one expected ray setup, result tdata layout plus the flag
  typedef struct {
    ray_t r;
    logic sat;
  } ray_setup_t;

  // shadow copy of the camera registers
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [POS_W-1:0] pos_x, pos_y;

  ray_setup_t rays_due[$];
  int  n_fail = 0;
  bit  idle_on = 1'b1;        // random gaps on both sides
  int  wdog = 0;

  // one axis: step, |1/dir|, first grid line distance; returns clip flag
  function automatic logic axis_calc(input longint rd, input logic [POS_W-1:0] pos,
                                     output logic [1:0] step,
                                     output logic [31:0] delta,
                                     output logic [31:0] side);
    longint unsigned frac, f, mag, q, s;
    logic clip;
    clip = 1'b0;
    frac = pos[15:0];
    if (rd < 0) begin
      step = STEP_NEG; f = frac; mag = -rd;
    end else begin
      step = STEP_POS; f = 65536 - frac; mag = rd;
    end
    if (mag == 0) begin
      delta = DIST_MAX; side = DIST_MAX;
      return 1'b1;
    end
    q = (64'd1 << 32) / mag;
    if (q > 64'hFFFF_FFFF) begin
      delta = DIST_MAX; clip = 1'b1;
    end else delta = q[31:0];
    s = (f * q) >> 16;
    if (s > 64'hFFFF_FFFF) begin
      side = DIST_MAX; clip = 1'b1;
    end else side = s[31:0];
    return clip;
  endfunction

  function automatic longint ray_comp(input longint d, input longint p, input longint cam);
    longint prod, v;
    prod = p * cam;
    v = d + (prod >>> 16);    // arithmetic shift is floor
    if (v < -262144) v = -262144;
    if (v > 262143) v = 262143;
    return v;
  endfunction

  function automatic ray_setup_t ray_predict(input logic [COL_W-1:0] col);
    ray_setup_t e;
    longint cam, rdx, rdy;
    logic cx, cy;
    cam = (longint'(col) * 2 * 65536) / NCOL - 65536;
    rdx = ray_comp(dir_x, plane_x, cam);
    rdy = ray_comp(dir_y, plane_y, cam);
    e.r.ray_dir_x = rdx[RAY_W-1:0];
    e.r.ray_dir_y = rdy[RAY_W-1:0];
    e.r.cell_x = pos_x[23:16];
    e.r.cell_y = pos_y[23:16];
    cx = axis_calc(rdx, pos_x, e.r.step_x_dir, e.r.delta_dist_x, e.r.side_dist_x);
    cy = axis_calc(rdy, pos_y, e.r.step_y_dir, e.r.delta_dist_y, e.r.side_dist_y);
    e.sat = cx | cy;
    return e;
  endfunction

  task automatic cam_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      CFG_VIEW_DIR_X:   dir_x   = val[DIR_W-1:0];
      CFG_VIEW_DIR_Y:   dir_y   = val[DIR_W-1:0];
      CFG_CAM_PLANE_X:  plane_x = val[DIR_W-1:0];
      CFG_CAM_PLANE_Y:  plane_y = val[DIR_W-1:0];
      CFG_VIEWER_POS_X: pos_x   = val;
      default:          pos_y   = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cam_set(input logic [CFG_W-1:0] dx, dy, px, py, vx, vy);
    cam_write(CFG_VIEW_DIR_X, dx);
    cam_write(CFG_VIEW_DIR_Y, dy);
    cam_write(CFG_CAM_PLANE_X, px);
    cam_write(CFG_CAM_PLANE_Y, py);
    cam_write(CFG_VIEWER_POS_X, vx);
    cam_write(CFG_VIEWER_POS_Y, vy);
  endtask

  // stop sending, wait until every ray has come back, then for the pipe
  // to go quiet
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (rays_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drives one column; random gap before it while idling is on
  task automatic send_column(input logic [COL_W-1:0] col, input bit chk_fixed,
                             input ray_setup_t fixed);
    ray_setup_t e;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, col};
    e = ray_predict(col);
    if (chk_fixed && (e.r !== fixed.r || e.sat !== fixed.sat)) begin
      $error("table row col=%0d: predictor %h/%b, table %h/%b",
             col, e.r, e.sat, fixed.r, fixed.sat);
      n_fail++;
    end
    rays_due.push_back(chk_fixed ? fixed : e);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // receiver: random stall bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker, sampled at the edge that accepts the item
  always @(posedge clk) begin
    ray_setup_t e;
    ray_t a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a = m_axis_tdata[185:0];
      if (rays_due.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        n_fail++;
      end else begin
        e = rays_due.pop_front();
        if (a.ray_dir_x !== e.r.ray_dir_x) begin
          $error("ray_dir_x exp %h got %h", e.r.ray_dir_x, a.ray_dir_x); n_fail++; end
        if (a.ray_dir_y !== e.r.ray_dir_y) begin
          $error("ray_dir_y exp %h got %h", e.r.ray_dir_y, a.ray_dir_y); n_fail++; end
        if (a.cell_x !== e.r.cell_x) begin
          $error("cell_x exp %h got %h", e.r.cell_x, a.cell_x); n_fail++; end
        if (a.cell_y !== e.r.cell_y) begin
          $error("cell_y exp %h got %h", e.r.cell_y, a.cell_y); n_fail++; end
        if (a.step_x_dir !== e.r.step_x_dir) begin
          $error("step_x_dir exp %h got %h", e.r.step_x_dir, a.step_x_dir); n_fail++; end
        if (a.step_y_dir !== e.r.step_y_dir) begin
          $error("step_y_dir exp %h got %h", e.r.step_y_dir, a.step_y_dir); n_fail++; end
        if (a.delta_dist_x !== e.r.delta_dist_x) begin
          $error("delta_dist_x exp %h got %h", e.r.delta_dist_x, a.delta_dist_x);
          n_fail++; end
        if (a.delta_dist_y !== e.r.delta_dist_y) begin
          $error("delta_dist_y exp %h got %h", e.r.delta_dist_y, a.delta_dist_y);
          n_fail++; end
        if (a.side_dist_x !== e.r.side_dist_x) begin
          $error("side_dist_x exp %h got %h", e.r.side_dist_x, a.side_dist_x);
          n_fail++; end
        if (a.side_dist_y !== e.r.side_dist_y) begin
          $error("side_dist_y exp %h got %h", e.r.side_dist_y, a.side_dist_y);
          n_fail++; end
        if (m_axis_tuser !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, m_axis_tuser); n_fail++; end
      end
    end
  end

  // watchdog: cycles with no item moved on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // directed table: column, camera preset, whether a fixed result applies
  typedef struct {
    logic [COL_W-1:0] col;
    int               preset;
    bit               fixed;
    ray_setup_t       want;
  } dir_row_t;

  function automatic ray_setup_t mk(input logic [18:0] rx, ry, input logic [1:0] sx, sy,
                                    input logic [31:0] dx, dy, ssx, ssy, input logic s);
    ray_setup_t e;
    e.r.ray_dir_x = rx; e.r.ray_dir_y = ry;
    e.r.cell_x = 8'd0; e.r.cell_y = 8'd0;
    e.r.step_x_dir = sx; e.r.step_y_dir = sy;
    e.r.delta_dist_x = dx; e.r.delta_dist_y = dy;
    e.r.side_dist_x = ssx; e.r.side_dist_y = ssy;
    e.sat = s;
    return e;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ray_setup_t none;
    int p, k, n_rand;
    logic [CFG_W-1:0] dx, dy, px, py;

    // reset camera
    dir_x = 18'sd65536; dir_y = '0; plane_x = '0; plane_y = 18'sd43254;
    pos_x = '0; pos_y = '0;
    none = mk('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);

    // after reset, center column: ray (1,0), y axis zero -> saturated
    rows.push_back('{10'd512, 0, 1'b1, mk(19'h10000, 19'h0, STEP_POS, STEP_POS,
                    32'h10000, DIST_MAX, 32'h10000, DIST_MAX, 1'b1)});
    rows.push_back('{10'd0,    0, 1'b0, none});
    rows.push_back('{10'd1023, 0, 1'b0, none});
    rows.push_back('{10'd1,    0, 1'b0, none});
    // preset 1: extreme directions, plane zero, maximum magnitudes on both axes
    rows.push_back('{10'd0,    1, 1'b0, none});
    rows.push_back('{10'd1023, 1, 1'b0, none});
    // preset 2: ray of one LSB on x, -1 LSB on y (quotient 2^32 clips)
    rows.push_back('{10'd512,  2, 1'b1, mk(19'h1, 19'h7FFFF, STEP_POS, STEP_NEG,
                    DIST_MAX, DIST_MAX, DIST_MAX, 32'h0, 1'b1)});
    // preset 3: extreme plane, ray from zero at column 0 to near the range ends
    rows.push_back('{10'd0,    3, 1'b0, none});
    rows.push_back('{10'd1023, 3, 1'b0, none});
    rows.push_back('{10'd700,  3, 1'b0, none});
    rows.push_back('{10'd300,  3, 1'b0, none});
    // preset 4: max positions, negative directions
    rows.push_back('{10'd0,    4, 1'b0, none});
    rows.push_back('{10'd512,  4, 1'b0, none});
    rows.push_back('{10'd1023, 4, 1'b0, none});
    rows.push_back('{10'd341,  4, 1'b0, none});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    p = 0;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.preset != p) begin
        wait_drained();
        p = row.preset;
        case (p)
          1: cam_set(24'h01FFFF, 24'h020000, 24'h0, 24'h0, 24'h00FFFF, 24'hFF0000);
          2: cam_set(24'h000001, 24'h03FFFF, 24'h0, 24'h0, 24'h0, 24'h0);
          3: cam_set(24'h01FFFF, 24'h020000, 24'h01FFFF, 24'h020000, 24'h7F8001,
                     24'h800000);
          default: cam_set(24'h030000, 24'h03C000, 24'h028000, 24'h018000,
                           24'hFFFFFF, 24'hFFFFFF);
        endcase
      end
      send_column(row.col, row.fixed, row.want);
    end

    // random phases: new camera each phase, columns over the full field
    n_rand = 0;
    while (n_rand < 1750) begin
      wait_drained();
      k = $urandom_range(0, 3);
      dx = (k == 0) ? 24'h0 : CFG_W'($urandom_range(0, 24'h3FFFF));
      dy = (k == 1) ? 24'h1 : CFG_W'($urandom_range(0, 24'h3FFFF));
      px = (k == 2) ? 24'h0 : CFG_W'($urandom_range(0, 24'h3FFFF));
      py = CFG_W'($urandom_range(0, 24'h3FFFF));
      cam_set(dx, dy, px, py, CFG_W'($urandom), CFG_W'($urandom));
      if (n_rand > 1500) idle_on = 1'b0;  // last stretch at full rate
      repeat ($urandom_range(40, 160)) begin
        send_column(COL_W'($urandom_range(0, NCOL - 1)), 1'b0, none);
        n_rand++;
      end
    end

    wait_drained();
    if (n_fail == 0 && rays_due.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/dda_pkg.sv
src/dda_cam.sv
src/dda_recip.sv
src/dda_side.sv
src/dda_ray_setup.sv
tb/tb_top.sv
